### rtl/srcc_pkg.sv
`timescale 1ns / 1ps
package srcc_pkg;

  localparam int OUT_FRAC_BITS = 15;
  localparam int CORR_W = OUT_FRAC_BITS + 1;
  localparam int KEPT_W = 10;

  typedef struct packed {
    logic signed [31:0] price;
    logic signed [31:0] volume;
    logic               missing;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic                     defined;
    logic [KEPT_W-1:0]        kept_samples;
  } out_item_t;

  typedef struct packed {
    logic insert;
    logic clear;
    logic load;
    logic rotate;
    logic drain;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANK_LOAD,
    ST_RANK,
    ST_DRAIN,
    ST_FLUSH,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_SEARCH,
    ST_KSQ,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NSXX,
    OP_SXSX,
    OP_NSYY,
    OP_SYSY,
    OP_NSXY,
    OP_SXSY,
    OP_AB,
    OP_CC,
    OP_LHS
  } op_t;

endpackage

### rtl/spearman_rank_correlation.sv
`timescale 1ns / 1ps
// Spearman rank correlation of one series of (price, volume) samples.
// Input transactions carry one sample each on in_valid/in_stall/in_data.
// A sample is kept unless it is missing, its volume is zero or less, or
// MAX_SAMPLES samples are already held. Kept samples enter a row of cells.
// Non-last samples are taken one per cycle. A transaction with last set ends
// the series and the input stalls until the result is loaded in the output
// register. One result transaction leaves on out_valid/out_stall/out_data.
// After last, ranking runs while the stored values circulate once around
// the ring of cells, then the ranks drain into the sums. The exact
// arithmetic runs on one shift-add multiplier: 8 products, then up to
// OUT_FRAC_BITS + 1 binary search steps of one product each. The output is
// Q1.15. The multiplier takes a BW-bit second operand, where
// BW = max(4 * clog2(MAX_SAMPLES + 1) + 4, 2 * OUT_FRAC_BITS + 4), 44 by
// default. A zero rank variance skips the last two products and the search;
// fewer than two kept samples skip ranking and go straight to the result.
// Reset empties the cells and the result register. A stalled result holds
// its value, and the block takes the next series while it waits.
module spearman_rank_correlation #(
  parameter int MAX_SAMPLES = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  srcc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output srcc_pkg::out_item_t  out_data
);
  import srcc_pkg::*;

  localparam int NB  = $clog2(MAX_SAMPLES + 1);
  localparam int RW  = NB + 1;
  localparam int AW  = 4 * NB + 4;
  localparam int KW  = 2 * OUT_FRAC_BITS + 4;
  localparam int BW  = (AW > KW) ? AW : KW;
  localparam int LW  = 2 * AW + 2 * OUT_FRAC_BITS + 4;
  localparam int QW  = OUT_FRAC_BITS + 2;

  state_t state_r, state_nxt;
  op_t    op_r;

  logic [NB-1:0] count_r;
  logic [NB-1:0] cnt_r;
  logic          kept;
  logic [NB-1:0] count_nxt;
  cell_ctl_t     ctl;

  logic               c_valid [MAX_SAMPLES];
  logic signed [31:0] c_price [MAX_SAMPLES];
  logic signed [31:0] c_vol   [MAX_SAMPLES];
  logic               t_valid [MAX_SAMPLES];
  logic signed [31:0] t_price [MAX_SAMPLES];
  logic signed [31:0] t_vol   [MAX_SAMPLES];
  logic [NB-1:0]      c_lp    [MAX_SAMPLES];
  logic [NB-1:0]      c_ep    [MAX_SAMPLES];
  logic [NB-1:0]      c_lv    [MAX_SAMPLES];
  logic [NB-1:0]      c_ev    [MAX_SAMPLES];

  logic          pv1_r, pv2_r;
  logic [RW-1:0] x_r, y_r;
  logic [2*RW-1:0] xx_r, yy_r, xy_r;
  logic [RW-1:0] x2_r, y2_r;
  logic [AW-1:0] sx_r, sy_r, sxx_r, syy_r, sxy_r;

  logic [AW-1:0] t_r, a_r, b_r, cmag_r;
  logic          neg_r;
  logic [LW-1:0] ab_r, rhs_r;
  logic [QW-1:0] lo_r, hi_r, mid_r;
  logic [KW-1:0] k2_r;
  logic          def_r;

  logic          mul_start;
  logic [LW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic          mul_done;
  logic [LW-1:0] mul_prod;

  logic [QW-1:0] mid_c;
  logic [QW-1:0] k_c;
  logic [CORR_W-1:0] corr_c;

  logic      out_valid_r;
  out_item_t out_data_r;

  assign kept = !in_data.missing && (in_data.volume > 0) &&
                (count_r < NB'(MAX_SAMPLES));
  assign count_nxt = count_r + NB'(kept);

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    localparam int PREV = (i == 0) ? MAX_SAMPLES - 1 : i - 1;
    logic               l_valid;
    logic signed [31:0] l_price, l_vol;
    logic [NB-1:0]      r_lp, r_ep, r_lv, r_ev;

    if (i == 0) begin : g_head
      assign l_valid = 1'b1;
      assign l_price = in_data.price;
      assign l_vol   = in_data.volume;
    end else begin : g_body
      assign l_valid = c_valid[i-1];
      assign l_price = c_price[i-1];
      assign l_vol   = c_vol[i-1];
    end

    if (i == MAX_SAMPLES - 1) begin : g_tail
      assign r_lp = '0;
      assign r_ep = '0;
      assign r_lv = '0;
      assign r_ev = '0;
    end else begin : g_mid
      assign r_lp = c_lp[i+1];
      assign r_ep = c_ep[i+1];
      assign r_lv = c_lv[i+1];
      assign r_ev = c_ev[i+1];
    end

    srcc_cell #(.CNT_W(NB)) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl            (ctl),
      .left_valid     (l_valid),
      .left_price     (l_price),
      .left_volume    (l_vol),
      .trav_in_valid  (t_valid[PREV]),
      .trav_in_price  (t_price[PREV]),
      .trav_in_volume (t_vol[PREV]),
      .right_less_p   (r_lp),
      .right_eq_p     (r_ep),
      .right_less_v   (r_lv),
      .right_eq_v     (r_ev),
      .own_valid      (c_valid[i]),
      .own_price      (c_price[i]),
      .own_volume     (c_vol[i]),
      .trav_valid     (t_valid[i]),
      .trav_price     (t_price[i]),
      .trav_volume    (t_vol[i]),
      .less_p         (c_lp[i]),
      .eq_p           (c_ep[i]),
      .less_v         (c_lv[i]),
      .eq_v           (c_ev[i])
    );
  end

  srcc_mul #(.A_W(LW), .B_W(BW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_r)
      OP_NSXX: begin mul_a = LW'(count_r); mul_b = BW'(sxx_r); end
      OP_SXSX: begin mul_a = LW'(sx_r);    mul_b = BW'(sx_r);  end
      OP_NSYY: begin mul_a = LW'(count_r); mul_b = BW'(syy_r); end
      OP_SYSY: begin mul_a = LW'(sy_r);    mul_b = BW'(sy_r);  end
      OP_NSXY: begin mul_a = LW'(count_r); mul_b = BW'(sxy_r); end
      OP_SXSY: begin mul_a = LW'(sx_r);    mul_b = BW'(sy_r);  end
      OP_AB:   begin mul_a = LW'(a_r);     mul_b = BW'(b_r);   end
      OP_CC:   begin mul_a = LW'(cmag_r);  mul_b = BW'(cmag_r); end
      OP_LHS:  begin mul_a = ab_r;         mul_b = BW'(k2_r);  end
      default: begin mul_a = '0;           mul_b = '0;         end
    endcase
  end

  assign mid_c = lo_r + ((hi_r - lo_r + 1'b1) >> 1);
  assign k_c   = (mid_r << 1) - 1'b1;

  always_comb begin
    if (!def_r) begin
      corr_c = '0;
    end else if (neg_r) begin
      corr_c = CORR_W'(-lo_r);
    end else if (lo_r > QW'((1 << OUT_FRAC_BITS) - 1)) begin
      corr_c = CORR_W'((1 << OUT_FRAC_BITS) - 1);
    end else begin
      corr_c = CORR_W'(lo_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_data.last) begin
          state_nxt = (count_nxt < NB'(2)) ? ST_OUT : ST_RANK_LOAD;
        end
      end
      ST_RANK_LOAD: state_nxt = ST_RANK;
      ST_RANK: begin
        if (cnt_r == NB'(MAX_SAMPLES - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cnt_r == count_r - 1'b1) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (cnt_r == NB'(1)) state_nxt = ST_MUL_START;
      end
      ST_MUL_START: state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          unique case (op_r)
            OP_SXSY: state_nxt = (a_r == '0 || b_r == '0) ? ST_OUT : ST_MUL_START;
            OP_CC:   state_nxt = ST_SEARCH;
            OP_LHS:  state_nxt = ST_SEARCH;
            default: state_nxt = ST_MUL_START;
          endcase
        end
      end
      ST_SEARCH: state_nxt = (lo_r < hi_r) ? ST_KSQ : ST_OUT;
      ST_KSQ:    state_nxt = ST_MUL_START;
      ST_OUT: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    mul_start = 1'b0;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:      ctl.insert = in_valid && kept;
      ST_RANK_LOAD: ctl.load   = 1'b1;
      ST_RANK:      ctl.rotate = 1'b1;
      ST_DRAIN:     ctl.drain  = 1'b1;
      ST_MUL_START: mul_start  = 1'b1;
      ST_OUT:       ctl.clear  = !out_valid_r || !out_stall;
      default:      ctl        = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pv1_r       <= 1'b0;
      pv2_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv1_r   <= (state_r == ST_DRAIN);
      pv2_r   <= pv1_r;
      if (state_r == ST_IDLE && in_valid) begin
        count_r <= count_nxt;
      end else if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        count_r <= '0;
      end
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= RW'({c_lp[0], 1'b0}) + RW'(c_ep[0]) + 1'b1;
    y_r  <= RW'({c_lv[0], 1'b0}) + RW'(c_ev[0]) + 1'b1;
    xx_r <= x_r * x_r;
    yy_r <= y_r * y_r;
    xy_r <= x_r * y_r;
    x2_r <= x_r;
    y2_r <= y_r;

    unique case (state_r)
      ST_IDLE: begin
        cnt_r <= '0;
        def_r <= 1'b0;
        neg_r <= 1'b0;
        lo_r  <= '0;
      end
      ST_RANK_LOAD: begin
        cnt_r <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
        sxx_r <= '0;
        syy_r <= '0;
        sxy_r <= '0;
      end
      ST_RANK, ST_DRAIN: begin
        cnt_r <= (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
      end
      ST_FLUSH: begin
        cnt_r <= cnt_r + 1'b1;
        op_r  <= OP_NSXX;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          unique case (op_r)
            OP_NSXX: begin t_r <= AW'(mul_prod); op_r <= OP_SXSX; end
            OP_SXSX: begin a_r <= t_r - AW'(mul_prod); op_r <= OP_NSYY; end
            OP_NSYY: begin t_r <= AW'(mul_prod); op_r <= OP_SYSY; end
            OP_SYSY: begin b_r <= t_r - AW'(mul_prod); op_r <= OP_NSXY; end
            OP_NSXY: begin t_r <= AW'(mul_prod); op_r <= OP_SXSY; end
            OP_SXSY: begin
              neg_r  <= t_r < AW'(mul_prod);
              cmag_r <= (t_r < AW'(mul_prod)) ? AW'(mul_prod) - t_r
                                               : t_r - AW'(mul_prod);
              op_r   <= OP_AB;
            end
            OP_AB: begin ab_r <= mul_prod; op_r <= OP_CC; end
            OP_CC: begin
              rhs_r <= mul_prod << (2 * OUT_FRAC_BITS + 2);
              lo_r  <= '0;
              hi_r  <= QW'(1 << OUT_FRAC_BITS);
              op_r  <= OP_LHS;
            end
            OP_LHS: begin
              if (mul_prod <= rhs_r) begin
                lo_r <= mid_r;
              end else begin
                hi_r <= mid_r - 1'b1;
              end
            end
            default: op_r <= OP_NSXX;
          endcase
        end
      end
      ST_SEARCH: begin
        mid_r <= mid_c;
        if (!(lo_r < hi_r)) begin
          def_r <= 1'b1;
        end
      end
      ST_KSQ: begin
        k2_r <= KW'(k_c * k_c);
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_r.correlation  <= corr_c;
          out_data_r.defined      <= def_r;
          out_data_r.kept_samples <= KEPT_W'(count_r);
        end
      end
      default: cnt_r <= cnt_r;
    endcase

    if (pv2_r) begin
      sx_r  <= sx_r + AW'(x2_r);
      sy_r  <= sy_r + AW'(y2_r);
      sxx_r <= sxx_r + AW'(xx_r);
      syy_r <= syy_r + AW'(yy_r);
      sxy_r <= sxy_r + AW'(xy_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/srcc_cell.sv
`timescale 1ns / 1ps
module srcc_cell #(
  parameter int CNT_W = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srcc_pkg::cell_ctl_t   ctl,
  input  logic                  left_valid,
  input  logic signed [31:0]    left_price,
  input  logic signed [31:0]    left_volume,
  input  logic                  trav_in_valid,
  input  logic signed [31:0]    trav_in_price,
  input  logic signed [31:0]    trav_in_volume,
  input  logic [CNT_W-1:0]      right_less_p,
  input  logic [CNT_W-1:0]      right_eq_p,
  input  logic [CNT_W-1:0]      right_less_v,
  input  logic [CNT_W-1:0]      right_eq_v,
  output logic                  own_valid,
  output logic signed [31:0]    own_price,
  output logic signed [31:0]    own_volume,
  output logic                  trav_valid,
  output logic signed [31:0]    trav_price,
  output logic signed [31:0]    trav_volume,
  output logic [CNT_W-1:0]      less_p,
  output logic [CNT_W-1:0]      eq_p,
  output logic [CNT_W-1:0]      less_v,
  output logic [CNT_W-1:0]      eq_v
);
  import srcc_pkg::*;

  logic                valid_r;
  logic signed [31:0]  price_r;
  logic signed [31:0]  volume_r;
  logic                trav_valid_r;
  logic signed [31:0]  trav_price_r;
  logic signed [31:0]  trav_volume_r;
  logic [CNT_W-1:0]    less_p_r;
  logic [CNT_W-1:0]    eq_p_r;
  logic [CNT_W-1:0]    less_v_r;
  logic [CNT_W-1:0]    eq_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      trav_valid_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        valid_r <= 1'b0;
      end else if (ctl.insert) begin
        valid_r <= left_valid;
      end
      if (ctl.load) begin
        trav_valid_r <= valid_r;
      end else if (ctl.rotate) begin
        trav_valid_r <= trav_in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      price_r  <= left_price;
      volume_r <= left_volume;
    end
    if (ctl.load) begin
      trav_price_r  <= price_r;
      trav_volume_r <= volume_r;
      less_p_r      <= '0;
      eq_p_r        <= '0;
      less_v_r      <= '0;
      eq_v_r        <= '0;
    end else if (ctl.rotate) begin
      trav_price_r  <= trav_in_price;
      trav_volume_r <= trav_in_volume;
      if (trav_valid_r) begin
        if (trav_price_r < price_r) begin
          less_p_r <= less_p_r + 1'b1;
        end else if (trav_price_r == price_r) begin
          eq_p_r <= eq_p_r + 1'b1;
        end
        if (trav_volume_r < volume_r) begin
          less_v_r <= less_v_r + 1'b1;
        end else if (trav_volume_r == volume_r) begin
          eq_v_r <= eq_v_r + 1'b1;
        end
      end
    end else if (ctl.drain) begin
      less_p_r <= right_less_p;
      eq_p_r   <= right_eq_p;
      less_v_r <= right_less_v;
      eq_v_r   <= right_eq_v;
    end
  end

  assign own_valid   = valid_r;
  assign own_price   = price_r;
  assign own_volume  = volume_r;
  assign trav_valid  = trav_valid_r;
  assign trav_price  = trav_price_r;
  assign trav_volume = trav_volume_r;
  assign less_p      = less_p_r;
  assign eq_p        = eq_p_r;
  assign less_v      = less_v_r;
  assign eq_v        = eq_v_r;

endmodule

### rtl/srcc_mul.sv
`timescale 1ns / 1ps
module srcc_mul #(
  parameter int A_W = 64,
  parameter int B_W = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic           done,
  output logic [A_W-1:0] prod
);
  import srcc_pkg::*;

  localparam int CW = $clog2(B_W + 1);

  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [A_W-1:0] acc_r;
  logic [A_W-1:0] a_r;
  logic [B_W-1:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### rtl/srcc_checker.sv
`timescale 1ns / 1ps
module srcc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input srcc_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input srcc_pkg::out_item_t out_data
);
  import srcc_pkg::*;

  // A stalled result transaction holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An undefined result carries a zero correlation.
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.defined |-> out_data.correlation == '0)
    else $error("undefined result with nonzero correlation");

  // A defined result needs at least two kept samples.
  a_def_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.defined |-> out_data.kept_samples != KEPT_W'(1))
    else $error("defined result from one sample");

  // The end of a series makes the input stall on the next cycle.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("input taken right after end of series");

endmodule

bind spearman_rank_correlation srcc_checker u_srcc_checker (.*);

### sim/tb_spearman_rank_correlation.sv
`timescale 1ns / 1ps
module tb_spearman_rank_correlation;
  import srcc_pkg::*;

  localparam int MAX_KEPT = 512;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 2500;

  typedef enum int {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_t;

  typedef struct {
    in_item_t  sample;
    bit        typed;
    out_item_t result;
  } directed_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  idle_phase_t phase = PH_FREE;
  bit          hold_start = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_cnt = 0;
  int          cycles = 0;
  int          fails = 0;
  int          items_sent = 0;

  int        price_col[MAX_KEPT];
  int        volume_col[MAX_KEPT];
  int        kept = 0;
  out_item_t expected_corr[$];

  spearman_rank_correlation dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("spearman_rank_correlation regression: fail");
      $finish;
    end
  end

  function automatic int unsigned doubled_rank(input int col[MAX_KEPT], input int n,
                                               input int idx);
    int unsigned less;
    int unsigned equal;
    less = 0;
    equal = 0;
    for (int j = 0; j < n; j++) begin
      if (col[j] < col[idx]) less++;
      else if (col[j] == col[idx]) equal++;
    end
    return 2 * less + equal + 1;
  endfunction

  function automatic out_item_t rank_correlation();
    out_item_t   res;
    logic [63:0] sx, sy, sxx, syy, sxy, x, y, a, b, cp, cn, cmag, nn;
    logic [255:0] ab, rhs, k, lhs;
    int unsigned lo, hi, mid;
    res = '0;
    res.kept_samples = kept[KEPT_W-1:0];
    sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
    if (kept < 2) return res;
    for (int i = 0; i < kept; i++) begin
      x = doubled_rank(price_col, kept, i);
      y = doubled_rank(volume_col, kept, i);
      sx += x; sy += y; sxx += x * x; syy += y * y; sxy += x * y;
    end
    nn = kept;
    a = nn * sxx - sx * sx;
    b = nn * syy - sy * sy;
    if (a == 0 || b == 0) return res;
    cp = nn * sxy;
    cn = sx * sy;
    cmag = (cp < cn) ? cn - cp : cp - cn;
    ab = 256'(a) * 256'(b);
    rhs = (256'(cmag) * 256'(cmag)) << (2 * OUT_FRAC_BITS + 2);
    lo = 0;
    hi = 1 << OUT_FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      k = 256'(2 * mid - 1);
      lhs = ab * k * k;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (cp < cn) res.correlation = -CORR_W'(lo);
    else res.correlation = (lo > (1 << OUT_FRAC_BITS) - 1) ? {1'b0, {OUT_FRAC_BITS{1'b1}}}
                                                          : CORR_W'(lo);
    res.defined = 1'b1;
    return res;
  endfunction

  function automatic bit take_sample(in_item_t it, output out_item_t res);
    res = '0;
    if (!it.missing && it.volume > 0 && kept < MAX_KEPT) begin
      price_col[kept] = it.price;
      volume_col[kept] = it.volume;
      kept++;
    end
    if (!it.last) return 1'b0;
    res = rank_correlation();
    kept = 0;
    return 1'b1;
  endfunction

  function automatic int idle_pct(bit sender);
    case (phase)
      PH_SEND_IDLE: return sender ? 87 : 0;
      PH_RECV_STALL: return sender ? 0 : 87;
      PH_BOTH: return 14;
      default: return 0;
    endcase
  endfunction

  task automatic send(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t res;
    bit        produced;
    while ($urandom_range(99) < idle_pct(1'b1)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    produced = take_sample(it, res);
    if (produced) expected_corr = {expected_corr, typed ? typed_res : res};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_start && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == 4000) hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct(1'b0));
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_corr.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        fails++;
      end else begin
        want = expected_corr.pop_front();
        if (out_data.correlation !== want.correlation) begin
          $display("%0t: correlation expected %0d actual %0d", $time,
                   want.correlation, out_data.correlation);
          fails++;
        end
        if (out_data.defined !== want.defined) begin
          $display("%0t: defined expected %0b actual %0b", $time, want.defined,
                   out_data.defined);
          fails++;
        end
        if (out_data.kept_samples !== want.kept_samples) begin
          $display("%0t: kept_samples expected %0d actual %0d", $time,
                   want.kept_samples, out_data.kept_samples);
          fails++;
        end
      end
    end
  end

  function automatic in_item_t random_sample(int style, int idx, bit last);
    in_item_t it;
    it.price = (style == 0) ? $urandom : $signed($urandom_range(8)) - 4;
    case ($urandom_range(19))
      0: it.volume = 0;
      1: it.volume = -$signed($urandom_range(1000));
      2: it.volume = $urandom;
      3: it.volume = 32'sh7fffffff;
      default: it.volume = $urandom_range(200) + 1;
    endcase
    if (style == 2) begin
      it.price = idx * 3 + $urandom_range(4);
      it.volume = ($urandom_range(1)) ? 1000 - idx : idx + 1;
    end
    it.missing = ($urandom_range(9) == 0);
    it.last = last;
    return it;
  endfunction

  task automatic random_series(int len, bit all_kept);
    in_item_t it;
    int       style;
    style = $urandom_range(2);
    for (int i = 0; i < len; i++) begin
      it = random_sample(style, i, i == len - 1);
      if (all_kept) begin
        it.missing = 1'b0;
        it.volume = $urandom_range(1000000) + 1;
      end
      send(it, 1'b0, '0);
    end
  endtask

  task automatic drain_expected();
    in_valid <= 1'b0;
    while (expected_corr.size() != 0) @(posedge clk);
  endtask

  directed_row_t rows[] = '{
    '{'{0, 1, 1'b1, 1'b1}, 1'b1, '{16'sd0, 1'b0, 10'd0}},
    '{'{5, 0, 1'b0, 1'b1}, 1'b1, '{16'sd0, 1'b0, 10'd0}},
    '{'{5, -1, 1'b0, 1'b1}, 1'b1, '{16'sd0, 1'b0, 10'd0}},
    '{'{32'sh80000000, 32'sh80000000, 1'b0, 1'b1}, 1'b1, '{16'sd0, 1'b0, 10'd0}},
    '{'{32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b1}, 1'b1, '{16'sd0, 1'b0, 10'd1}},
    '{'{32'sh80000000, 1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b1}, 1'b1, '{16'sd32767, 1'b1, 10'd2}},
    '{'{32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'sh7fffffff, 1, 1'b0, 1'b1}, 1'b1, '{-16'sd32768, 1'b1, 10'd2}},
    '{'{7, 3, 1'b0, 1'b0}, 1'b0, '0},
    '{'{7, 9, 1'b0, 1'b1}, 1'b1, '{16'sd0, 1'b0, 10'd2}},
    '{'{1, 5, 1'b0, 1'b0}, 1'b0, '0},
    '{'{2, 5, 1'b0, 1'b0}, 1'b0, '0},
    '{'{3, 5, 1'b1, 1'b0}, 1'b0, '0},
    '{'{3, 5, 1'b0, 1'b1}, 1'b1, '{16'sd0, 1'b0, 10'd3}},
    '{'{-1, 10, 1'b0, 1'b0}, 1'b0, '0},
    '{'{0, 20, 1'b0, 1'b0}, 1'b0, '0},
    '{'{0, 30, 1'b0, 1'b0}, 1'b0, '0},
    '{'{1, 25, 1'b0, 1'b1}, 1'b0, '0},
    '{'{3, 1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{-3, 2, 1'b0, 1'b0}, 1'b0, '0},
    '{'{3, 3, 1'b0, 1'b1}, 1'b0, '0}
  };

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send(rows[i].sample, rows[i].typed, rows[i].result);
    drain_expected();
    hold_start = 1'b1;
    random_series(40, 1'b0);
    random_series(520, 1'b1);
    random_series(10, 1'b0);
    drain_expected();
    for (int p = PH_FREE; p <= PH_BOTH; p++) begin
      phase = idle_phase_t'(p);
      while (items_sent < 500 + 170 * (p + 1)) begin
        random_series(($urandom_range(15) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(0, 20), 1'b0);
      end
      drain_expected();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("spearman_rank_correlation regression: pass");
    end else begin
      $display("spearman_rank_correlation regression: fail");
    end
    $finish;
  end

endmodule
